>>> rtl/core/brs_pkg.sv
// Shared types, constants and helpers for the bilinear RGBA scaler.
`default_nettype none
package brs_pkg;

  localparam int MAX_SIDE = 512;
  localparam int SIDE_W   = 9;           // bits of a coordinate
  localparam int DIM_W    = 10;          // bits of an image size register
  localparam int FRAC_W   = 24;
  localparam int STEP_W   = 34;          // step may reach MAX_SIDE << 24
  localparam int W_W      = FRAC_W + 1;  // weight 0..1<<24
  localparam int ADDR_W   = 2 * SIDE_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [W_W-1:0] ONE_FX  = W_W'(1) << FRAC_W;
  localparam logic [W_W-1:0] HALF_FX = W_W'(1) << (FRAC_W - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_PRODUCE = 1'b1;

  typedef struct packed {
    logic              action;
    logic [SIDE_W-1:0] col;
    logic [SIDE_W-1:0] row;
    logic [31:0]       pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [SIDE_W-1:0] out_col;
    logic [SIDE_W-1:0] out_row;
    logic [31:0]       out_pixel;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic calc_step;   // 1: derive step, 0: taps for coordinate
  } axis_cmd_t;

  typedef struct packed {
    logic              ready;
    logic [SIDE_W-1:0] t0;
    logic [SIDE_W-1:0] t1;
    logic [W_W-1:0]    w;
  } axis_stat_t;

  // size register saturated into 1..MAX_SIDE
  function automatic logic [DIM_W-1:0] eff(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_SIDE)) r = DIM_W'(MAX_SIDE);
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/brs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module brs_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [brs_pkg::STEP_W-1:0] dividend,
  input  wire logic [brs_pkg::DIM_W-1:0]  divisor,
  output logic                            ready,
  output logic [brs_pkg::STEP_W-1:0]      quotient
);
  import brs_pkg::*;

  localparam int CNT_W = $clog2(STEP_W + 1);

  logic [STEP_W-1:0] acc;   // dividend bits out the top, quotient bits in
  logic [DIM_W-1:0]  rem;
  logic [DIM_W-1:0]  dvs;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIM_W:0]    trial;
  logic              fits;

  assign trial = {rem, acc[STEP_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start && !busy) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(STEP_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      acc <= {acc[STEP_W-2:0], fits};
      rem <= fits ? DIM_W'(trial - {1'b0, dvs}) : trial[DIM_W-1:0];
    end
  end

  assign ready    = !busy;
  assign quotient = acc;
endmodule
`default_nettype wire

>>> rtl/core/brs_axis.sv
// One axis: holds the step, finds the two taps and the first tap's weight.
`default_nettype none
module brs_axis (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire brs_pkg::axis_cmd_t        cmd,
  input  wire logic [brs_pkg::DIM_W-1:0]  s_size,
  input  wire logic [brs_pkg::DIM_W-1:0]  d_size,
  input  wire logic [brs_pkg::SIDE_W-1:0] coord,
  output brs_pkg::axis_stat_t            stat
);
  import brs_pkg::*;

  localparam int PROD_W = STEP_W + SIDE_W;
  localparam int C_W    = PROD_W + 2;
  localparam int NUM_W  = C_W + 2;

  typedef enum logic [6:0] {
    A_IDLE = 7'b0000001,
    A_SDIV = 7'b0000010,
    A_MUL  = 7'b0000100,
    A_GEO1 = 7'b0001000,
    A_GEO2 = 7'b0010000,
    A_GEO3 = 7'b0100000,
    A_WDIV = 7'b1000000
  } axis_state_t;

  axis_state_t       state;
  logic [STEP_W-1:0] step;
  logic              shrink;
  logic [SIDE_W-1:0] x;
  logic [PROD_W-1:0] prod;
  logic [C_W-1:0]    c;
  logic [SIDE_W-1:0] t0, t1;
  logic [W_W-1:0]    w;

  logic              div_start;
  logic [STEP_W-1:0] div_dividend;
  logic [DIM_W-1:0]  div_divisor;
  logic              div_ready;
  logic [STEP_W-1:0] div_q;

  logic [DIM_W-1:0]  s_last;
  logic [C_W:0]      lo, hi;
  logic [PROD_W-SIDE_W-FRAC_W+SIDE_W-1:0] ip;
  logic [SIDE_W:0]   tap_gap;
  logic signed [NUM_W-1:0] num;
  logic              is_shrink_cfg;

  assign s_last        = s_size - DIM_W'(1);
  assign is_shrink_cfg = s_size >= d_size;
  assign lo   = {1'b0, c} - (C_W + 1)'(step);
  assign hi   = {1'b0, c} + (C_W + 1)'(step);
  assign ip   = prod[PROD_W-1:FRAC_W];
  assign tap_gap = {1'b0, t1} - {1'b0, t0};
  // num = tap_gap<<26 - (c - t0<<26 - 1<<25)
  assign num  = $signed(NUM_W'({tap_gap, 26'b0}) + NUM_W'({t0, 26'b0}) + (NUM_W'(1) << 25))
              - $signed(NUM_W'(c));

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = DIM_W'(1);
    if (state == A_IDLE && cmd.start && cmd.calc_step) begin
      div_start = 1'b1;
      if (is_shrink_cfg) begin
        div_dividend = {s_size, 24'b0};
        div_divisor  = d_size;
      end else begin
        div_dividend = {s_last, 24'b0};
        div_divisor  = d_size - DIM_W'(1);
      end
    end else if (state == A_GEO3 && t0 != t1 && !num[NUM_W-1] && num != '0) begin
      div_start    = 1'b1;
      div_dividend = num[STEP_W+1:2];
      div_divisor  = DIM_W'(tap_gap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      case (state)
        A_IDLE: if (cmd.start) state <= cmd.calc_step ? A_SDIV : A_MUL;
        A_SDIV: if (div_ready) state <= A_IDLE;
        A_MUL:  state <= A_GEO1;
        A_GEO1: state <= shrink ? A_GEO2 : A_IDLE;
        A_GEO2: state <= A_GEO3;
        A_GEO3: state <= div_start ? A_WDIV : A_IDLE;
        A_WDIV: if (div_ready) state <= A_IDLE;
        default: state <= A_IDLE;
      endcase
    end
  end

  // step and shrink flag are derived state; reset sets step to 0 and shrink to 1
  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      shrink <= 1'b1;
    end else begin
      if (state == A_IDLE && cmd.start && cmd.calc_step) shrink <= is_shrink_cfg;
      if (state == A_SDIV && div_ready) step <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: if (cmd.start) x <= coord;
      A_MUL:  prod <= step * PROD_W'(x);
      A_GEO1: begin
        if (shrink) begin
          c <= {prod, 2'b0} + C_W'({step, 1'b0});
        end else begin
          t0 <= (ip > (PROD_W-FRAC_W)'(s_last)) ? s_last[SIDE_W-1:0] : ip[SIDE_W-1:0];
          t1 <= (ip + (PROD_W-FRAC_W)'(1) > (PROD_W-FRAC_W)'(s_last))
                ? s_last[SIDE_W-1:0] : SIDE_W'(ip + (PROD_W-FRAC_W)'(1));
          w  <= ONE_FX - W_W'(prod[FRAC_W-1:0]);
        end
      end
      A_GEO2: begin
        t0 <= (lo[C_W:26] > (C_W-25)'(s_last)) ? s_last[SIDE_W-1:0] : SIDE_W'(lo[C_W:26]);
        t1 <= (hi[C_W:26] > (C_W-25)'(s_last)) ? s_last[SIDE_W-1:0] : SIDE_W'(hi[C_W:26]);
      end
      A_GEO3: begin
        if (t0 == t1) w <= ONE_FX;
        else if (!div_start) w <= '0;
      end
      A_WDIV: if (div_ready) w <= (div_q > STEP_W'(ONE_FX)) ? ONE_FX : div_q[W_W-1:0];
      default: ;
    endcase
  end

  brs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .ready    (div_ready),
    .quotient (div_q)
  );

  assign stat.ready = (state == A_IDLE);
  assign stat.t0    = t0;
  assign stat.t1    = t1;
  assign stat.w     = w;
endmodule
`default_nettype wire

>>> rtl/core/brs_frame.sv
// Source frame store: one port, synchronous read with a registered output.
`default_nettype none
module brs_frame (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic                       re,
  input  wire logic [brs_pkg::ADDR_W-1:0] addr,
  input  wire logic [31:0]                wdata,
  output logic [31:0]                     rdata
);
  import brs_pkg::*;

  logic [31:0] mem [MAX_SIDE*MAX_SIDE];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    else if (re) rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> rtl/core/bilinear_rgba_scaler.sv
// Top level of the bilinear RGBA scaler: control, frame reads and channel blend.
`default_nettype none
// A load writes the frame store and the scaler stays idle. A produce finds the taps,
// running the radix-2 weight divider only when shrinking with two distinct taps and
// a nonzero weight, then reads the four tap pixels and blends each channel, first
// horizontally, then vertically. Input is taken again the cycle after the result
// registers unless a register write is pending. After reset or a known-register
// write both step divisions run first. rst is synchronous; frame store not cleared.
module bilinear_rgba_scaler (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          src_valid,
  output logic                               src_stall,
  input  wire brs_pkg::in_item_t             src_item,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output brs_pkg::out_item_t                 res_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [brs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [brs_pkg::DIM_W-1:0]     cfg_data
);
  import brs_pkg::*;

  typedef enum logic [7:0] {
    ST_INIT    = 8'b00000001,
    ST_DERIVE  = 8'b00000010,
    ST_IDLE    = 8'b00000100,
    ST_TAPS    = 8'b00001000,
    ST_READ    = 8'b00010000,
    ST_BLEND_H = 8'b00100000,
    ST_BLEND_V = 8'b01000000,
    ST_HOLD    = 8'b10000000
  } top_state_t;

  top_state_t state;

  // configuration registers
  logic [DIM_W-1:0] src_width, src_height, dst_width, dst_height;
  logic [DIM_W-1:0] sw_eff, sh_eff, dw_eff, dh_eff;
  logic             cfg_hit;

  assign sw_eff = eff(src_width);
  assign sh_eff = eff(src_height);
  assign dw_eff = eff(dst_width);
  assign dh_eff = eff(dst_height);

  assign cfg_ready = (state == ST_IDLE);
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     (cfg_index == REG_SRC_WIDTH || cfg_index == REG_SRC_HEIGHT ||
                      cfg_index == REG_DST_WIDTH || cfg_index == REG_DST_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DIM_W'(1);
      src_height <= DIM_W'(1);
      dst_width  <= DIM_W'(1);
      dst_height <= DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        REG_DST_WIDTH:  dst_width  <= cfg_data;
        REG_DST_HEIGHT: dst_height <= cfg_data;
        default: ;   // unknown index: dropped
      endcase
    end
  end

  // input handshake: only taken when idle and not racing a register write
  logic src_take, is_load, is_produce;
  assign src_stall  = (state != ST_IDLE) || cfg_valid;
  assign src_take   = src_valid && !src_stall;
  assign is_load    = src_take && src_item.action == ACT_LOAD;
  assign is_produce = src_take && src_item.action == ACT_PRODUCE &&
                      {1'b0, src_item.col} < dw_eff && {1'b0, src_item.row} < dh_eff;

  // axis units
  axis_cmd_t  ax_cmd;
  axis_stat_t hx, vy;
  assign ax_cmd.start     = (state == ST_INIT) || is_produce;
  assign ax_cmd.calc_step = (state == ST_INIT);

  brs_axis u_axis_h (
    .clk    (clk),
    .rst    (rst),
    .cmd    (ax_cmd),
    .s_size (sw_eff),
    .d_size (dw_eff),
    .coord  (src_item.col),
    .stat   (hx)
  );

  brs_axis u_axis_v (
    .clk    (clk),
    .rst    (rst),
    .cmd    (ax_cmd),
    .s_size (sh_eff),
    .d_size (dh_eff),
    .coord  (src_item.row),
    .stat   (vy)
  );

  // frame store: writes on load transactions, four tap reads per produce
  logic [2:0]        rd_cnt;     // issue index 0..3, last capture at 4
  logic [1:0]        cap_idx;
  logic              fr_re;
  logic [ADDR_W-1:0] fr_addr;
  logic [31:0]       fr_rdata;
  logic [SIDE_W-1:0] tap_c, tap_r;

  assign fr_re   = (state == ST_READ) && !rd_cnt[2];
  assign tap_c   = rd_cnt[0] ? hx.t1 : hx.t0;
  assign tap_r   = rd_cnt[1] ? vy.t1 : vy.t0;
  assign fr_addr = is_load ? {src_item.row, src_item.col} : {tap_r, tap_c};
  assign cap_idx = rd_cnt[1:0] - 2'd1;

  brs_frame u_frame (
    .clk   (clk),
    .we    (is_load),
    .re    (fr_re),
    .addr  (fr_addr),
    .wdata (src_item.pixel_in),
    .rdata (fr_rdata)
  );

  // pix[0]=p00, pix[1]=p01, pix[2]=p10, pix[3]=p11
  logic [31:0]       pix [4];
  logic [SIDE_W-1:0] cur_col, cur_row;
  logic [1:0]        ch;
  logic [7:0]        h0, h1;
  logic [31:0]       acc_pix;

  // channel blend: each channel passes through ST_BLEND_H, then ST_BLEND_V
  logic [7:0]  ba, bb, bc, bd;
  logic signed [8:0]  dab, dcd, dh;
  logic signed [35:0] h0_full, h1_full, v_full;

  assign ba  = pix[0][{ch, 3'b0} +: 8];
  assign bb  = pix[1][{ch, 3'b0} +: 8];
  assign bc  = pix[2][{ch, 3'b0} +: 8];
  assign bd  = pix[3][{ch, 3'b0} +: 8];
  assign dab = $signed({1'b0, ba}) - $signed({1'b0, bb});
  assign dcd = $signed({1'b0, bc}) - $signed({1'b0, bd});
  assign dh  = $signed({1'b0, h0}) - $signed({1'b0, h1});
  // a*w + b*(1-w) == b<<24 + (a-b)*w
  assign h0_full = $signed({4'b0, bb, 24'b0}) + dab * $signed({1'b0, hx.w});
  assign h1_full = $signed({4'b0, bd, 24'b0}) + dcd * $signed({1'b0, hx.w});
  assign v_full  = $signed({4'b0, h1, 24'b0}) + dh * $signed({1'b0, vy.w})
                 + $signed(36'(HALF_FX));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_INIT;
      rd_cnt <= '0;
      ch     <= '0;
    end else begin
      case (state)
        ST_INIT:   state <= ST_DERIVE;
        ST_DERIVE: if (hx.ready && vy.ready) state <= ST_IDLE;
        ST_IDLE: begin
          if (cfg_hit) state <= ST_INIT;
          else if (is_produce) state <= ST_TAPS;
        end
        ST_TAPS: begin
          rd_cnt <= '0;
          if (hx.ready && vy.ready) state <= ST_READ;
        end
        ST_READ: begin
          rd_cnt <= rd_cnt + 3'd1;
          if (rd_cnt[2]) begin
            ch    <= '0;
            state <= ST_BLEND_H;
          end
        end
        ST_BLEND_H: state <= ST_BLEND_V;
        ST_BLEND_V: begin
          ch <= ch + 2'd1;
          if (ch == 2'd3) state <= ST_HOLD;
          else state <= ST_BLEND_H;
        end
        ST_HOLD: if (!res_valid || !res_stall) state <= ST_IDLE;
        default: state <= ST_INIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (is_produce) begin
      cur_col <= src_item.col;
      cur_row <= src_item.row;
    end
    if (state == ST_READ && rd_cnt != 3'd0) pix[cap_idx] <= fr_rdata;
    if (state == ST_BLEND_H) begin
      h0 <= h0_full[31:24];
      h1 <= h1_full[31:24];
    end
    if (state == ST_BLEND_V) acc_pix[{ch, 3'b0} +: 8] <= v_full[31:24];
  end

  // output register: the next item may be taken while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_HOLD && (!res_valid || !res_stall)) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && (!res_valid || !res_stall)) begin
      res_item.out_col   <= cur_col;
      res_item.out_row   <= cur_row;
      res_item.out_pixel <= acc_pix;
    end
  end
endmodule
`default_nettype wire
